/* rtl/scld_pkg.sv */
// ============================================================================
// scld_pkg
// Shared types and constants of the serial command line decoder: character
// codes, character classes, command letters, action codes and register
// indexes.
// ============================================================================
`default_nettype none

package scld_pkg;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Command letters.
    localparam logic [7:0] CMD_PING  = 8'h70;  // 'p'
    localparam logic [7:0] CMD_TIME  = 8'h74;  // 't'
    localparam logic [7:0] CMD_ERROR = 8'h65;  // 'e'
    localparam logic [7:0] CMD_RGB   = 8'h6c;  // 'l'
    localparam logic [7:0] CMD_WHITE = 8'h77;  // 'w'
    localparam logic [7:0] CMD_NONE  = 8'h00;

    // Character classes, decided by the front end.
    localparam logic [1:0] CLS_OTHER   = 2'd0;
    localparam logic [1:0] CLS_DIGIT   = 2'd1;
    localparam logic [1:0] CLS_NEWLINE = 2'd2;

    // Action codes of a finished line.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_PING  = 3'd1;
    localparam logic [2:0] ACT_TIME  = 3'd2;
    localparam logic [2:0] ACT_RGB   = 3'd3;
    localparam logic [2:0] ACT_WHITE = 3'd4;

    // Parameter checks.
    localparam int          RGB_MIN_PARAMS   = 3;
    localparam int          WHITE_MIN_PARAMS = 2;
    localparam logic [31:0] CHANNEL_LIMIT    = 32'd3;
    localparam logic [31:0] LEVEL_LIMIT      = 32'd255;

    // Configuration register indexes.
    localparam logic [7:0] REG_RGB_LED_LIMIT   = 8'd0;
    localparam logic [7:0] REG_WHITE_LED_LIMIT = 8'd1;

    localparam logic [7:0] RGB_LIMIT_RESET   = 8'd4;
    localparam logic [7:0] WHITE_LIMIT_RESET = 8'd1;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] ch;
    } scld_item_t;

    typedef struct packed {
        logic [7:0] rgb_led_limit;
        logic [7:0] white_led_limit;
    } scld_cfg_t;

endpackage

`default_nettype wire

/* rtl/scld_front.sv */
// ============================================================================
// scld_front
// Accepts received characters, classifies each one as digit, newline or
// other, and holds them in a two-entry queue for the back end.
// ============================================================================
`default_nettype none

module scld_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_char,
    output logic                    q_valid,
    output scld_pkg::scld_item_t    q_item,
    input  wire logic               q_pop
);
    import scld_pkg::*;

    scld_item_t entry_reg [2];
    scld_item_t new_item;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    always_comb begin
        new_item.ch = s_rx_char;
        if (s_rx_char == CH_NEWLINE) begin
            new_item.cls = CLS_NEWLINE;
        end else if (s_rx_char >= CH_ZERO && s_rx_char <= CH_NINE) begin
            new_item.cls = CLS_DIGIT;
        end else begin
            new_item.cls = CLS_OTHER;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    // The occupancy always matches the distance between the pointers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue count and pointers disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue lost an accepted character");

endmodule

`default_nettype wire

/* rtl/scld_back.sv */
// ============================================================================
// scld_back
// Executes classified characters: captures the command letter, builds the
// decimal parameters and, on newline, checks the line and loads the result
// register.
// ============================================================================
`default_nettype none

module scld_back #(
    parameter int MAX_PARAMS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire scld_pkg::scld_cfg_t cfg,
    input  wire logic               q_valid,
    input  wire scld_pkg::scld_item_t q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_command_code,
    output logic [2:0]              m_param_count,
    output logic [31:0]             m_param_a,
    output logic [31:0]             m_param_b,
    output logic [31:0]             m_param_c,
    output logic [31:0]             m_param_d,
    output logic                    m_line_valid,
    output logic [2:0]              m_action
);
    import scld_pkg::*;

    localparam int IW = $clog2(MAX_PARAMS);
    localparam int CW = $clog2(MAX_PARAMS + 1);

    logic [7:0]    cmd_reg, cmd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          seen_reg, seen_next;
    logic [31:0]   store_reg [MAX_PARAMS];
    logic [31:0]   acc_base;
    logic [31:0]   acc_value;
    logic          store_we;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_cmd_reg;
    logic [2:0]    out_count_reg;
    logic [31:0]   out_param_reg [4];
    logic          out_line_valid_reg;
    logic [2:0]    out_action_reg;

    logic [CW-1:0] count;
    logic [31:0]   res_param [4];
    logic          res_valid;
    logic [2:0]    res_action;
    logic          out_free;
    logic          is_newline;
    logic          take_line;

    assign out_free   = !out_valid_reg || m_ready;
    assign is_newline = (q_item.cls == CLS_NEWLINE);
    assign q_pop      = q_valid && (!is_newline || out_free);
    assign take_line  = q_pop && is_newline;

    // value * 10 + digit, built from two shifts.
    assign acc_base  = seen_reg ? store_reg[idx_reg] : 32'd0;
    assign acc_value = (acc_base << 3) + (acc_base << 1) + {28'd0, q_item.ch[3:0]};

    always_comb begin
        cmd_next  = cmd_reg;
        idx_next  = idx_reg;
        seen_next = seen_reg;
        store_we  = 1'b0;
        if (q_pop) begin
            if (is_newline) begin
                cmd_next  = CMD_NONE;
                idx_next  = '0;
                seen_next = 1'b0;
            end else if (cmd_reg == CMD_NONE) begin
                cmd_next = q_item.ch;
            end else if (q_item.cls == CLS_DIGIT) begin
                store_we  = 1'b1;
                seen_next = 1'b1;
            end else if (seen_reg) begin
                seen_next = 1'b0;
                if (idx_reg == IW'(MAX_PARAMS - 1)) begin
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    // A digit run still open at newline counts as a parameter.
    assign count = CW'(idx_reg) + CW'(seen_reg);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            res_param[k] = 32'd0;
            if (k < MAX_PARAMS && CW'(k) < count) begin
                res_param[k] = store_reg[k % MAX_PARAMS];
            end
        end
    end

    always_comb begin
        res_valid  = 1'b0;
        res_action = ACT_NONE;
        case (cmd_reg)
            CMD_PING: begin
                res_valid  = 1'b1;
                res_action = ACT_PING;
            end
            CMD_TIME: begin
                res_valid  = 1'b1;
                res_action = ACT_TIME;
            end
            CMD_RGB: begin
                res_valid = (count >= CW'(RGB_MIN_PARAMS))
                    && (store_reg[0] < {24'd0, cfg.rgb_led_limit})
                    && (store_reg[1] < CHANNEL_LIMIT)
                    && (store_reg[2] < LEVEL_LIMIT);
                res_action = res_valid ? ACT_RGB : ACT_NONE;
            end
            CMD_WHITE: begin
                res_valid = (count >= CW'(WHITE_MIN_PARAMS))
                    && (store_reg[0] < {24'd0, cfg.white_led_limit})
                    && (store_reg[1] < LEVEL_LIMIT);
                res_action = res_valid ? ACT_WHITE : ACT_NONE;
            end
            CMD_ERROR: begin
                res_valid  = 1'b0;
                res_action = ACT_NONE;
            end
            default: begin
                res_valid  = 1'b0;
                res_action = ACT_NONE;
            end
        endcase
    end

    always_comb begin
        if (take_line) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_NONE;
            idx_reg       <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[idx_reg] <= acc_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_line) begin
            out_cmd_reg        <= cmd_reg;
            out_count_reg      <= 3'(count);
            out_param_reg      <= res_param;
            out_line_valid_reg <= res_valid;
            out_action_reg     <= res_action;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_command_code = out_cmd_reg;
    assign m_param_count  = out_count_reg;
    assign m_param_a      = out_param_reg[0];
    assign m_param_b      = out_param_reg[1];
    assign m_param_c      = out_param_reg[2];
    assign m_param_d      = out_param_reg[3];
    assign m_line_valid   = out_line_valid_reg;
    assign m_action       = out_action_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        take_line |=> (out_valid_reg && cmd_reg == CMD_NONE && !seen_reg && idx_reg == '0))
        else $error("newline did not post a result and clear the line");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_line_valid_reg == (out_action_reg != ACT_NONE)))
        else $error("line valid flag and action code disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !take_line)
        else $error("result register overwritten while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> (cmd_reg != CMD_NONE))
        else $error("parameter written before a command letter");

endmodule

`default_nettype wire

/* rtl/serial_command_line_decoder_core.sv */
// ============================================================================
// serial_command_line_decoder_core
// Command line decoder for a serial console: characters in, one checked
// command result per line out.
// ============================================================================
// Usage:
//   The s_ channel takes one received character per accepted request. Lines
//   start with a command letter, decimal digit runs become 32-bit parameters
//   and a newline (10) closes the line. Each newline gives exactly one
//   request on the m_ channel with the command, parameter count, up to four
//   parameters, a line valid flag and an action code; no other character
//   gives a result.
//   The cfg_ channel writes the LED limits (index 0: RGB, index 1: white);
//   writes to other indexes are ignored. Write it only while the block idles.
//   Throughput is one character per cycle while s_ready is high. An accepted
//   newline is written into the two-entry front queue; once it reaches the
//   head and the result register is free, the back end pops it and loads the
//   result register, which drives m_valid until m_ready takes it.
//   When the receiver stalls, the result register holds and the back end
//   keeps working on non-newline characters; s_ready drops once a second
//   newline and one more character wait behind an untaken result.
//   Reset (aresetn low, synchronous) empties the queue, clears the line
//   state and the result valid flag and restores the LED limits to 4 and 1.
// ============================================================================
`default_nettype none

module serial_command_line_decoder_core #(
    parameter int MAX_PARAMS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_char,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_command_code,
    output logic [2:0]       m_param_count,
    output logic [31:0]      m_param_a,
    output logic [31:0]      m_param_b,
    output logic [31:0]      m_param_c,
    output logic [31:0]      m_param_d,
    output logic             m_line_valid,
    output logic [2:0]       m_action,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import scld_pkg::*;

    scld_cfg_t  cfg_reg;
    scld_cfg_t  cfg_next;
    scld_item_t q_item;
    logic       q_valid;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_RGB_LED_LIMIT:   cfg_next.rgb_led_limit   = cfg_data;
                REG_WHITE_LED_LIMIT: cfg_next.white_led_limit = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rgb_led_limit   <= RGB_LIMIT_RESET;
            cfg_reg.white_led_limit <= WHITE_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_char (s_rx_char),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    scld_back #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_code (m_command_code),
        .m_param_count  (m_param_count),
        .m_param_a      (m_param_a),
        .m_param_b      (m_param_b),
        .m_param_c      (m_param_c),
        .m_param_d      (m_param_d),
        .m_line_valid   (m_line_valid),
        .m_action       (m_action)
    );

endmodule

`default_nettype wire
